// ===== rtl/core/hsv_pkg.sv =====
// Shared types and constants for the RGB to HSV pixel converter.
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 9;
    localparam int NUM_HUE_W = 14;   // 60 * 255 fits in 14 bits
    localparam int NUM_W     = 16;   // 255 * 255 fits in 16 bits
    localparam int QUO_W     = 8;    // quotient bits, one per divider stage
    localparam int ANG_W     = 6;    // sector angle 0..60

    localparam logic [HUE_W-1:0] HUE_BASE_G = 9'd120;
    localparam logic [HUE_W-1:0] HUE_BASE_B = 9'd240;
    localparam logic [HUE_W-1:0] HUE_FULL   = 9'd360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // Per-item sideband that rides along the pipeline
    typedef struct packed {
        sector_t           sector;
        logic              neg;     // sector difference was negative
        logic              grey;    // all channels equal
        logic [CH_W-1:0]   value;   // largest channel
    } side_t;

endpackage

// ===== rtl/core/hsv_prep.sv =====
// Front stages: max/min, sector pick, then numerators for hue and saturation.
`timescale 1ns / 1ps

module hsv_prep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [hsv_pkg::CH_W-1:0]     red,
    input  logic [hsv_pkg::CH_W-1:0]     green,
    input  logic [hsv_pkg::CH_W-1:0]     blue,
    output logic                         out_valid,
    output logic [hsv_pkg::NUM_W-1:0]    num_hue,
    output logic [hsv_pkg::NUM_W-1:0]    num_sat,
    output logic [hsv_pkg::CH_W-1:0]     delta,
    output hsv_pkg::side_t               side
);
    import hsv_pkg::*;

    // stage 1
    logic            valid1_reg;
    side_t           side1_reg, side1_next;
    logic [CH_W-1:0] delta1_reg, delta1_next;
    logic [CH_W-1:0] mag1_reg, mag1_next;

    // stage 2
    logic                 valid2_reg;
    side_t                side2_reg;
    logic [CH_W-1:0]      delta2_reg;
    logic [NUM_W-1:0]     num_hue2_reg, num_hue2_next;
    logic [NUM_W-1:0]     num_sat2_reg, num_sat2_next;

    logic [CH_W-1:0] mx, mn, pos, sub;

    always_comb
    begin
        mx = red;
        if (green > mx) mx = green;
        if (blue > mx)  mx = blue;
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn)  mn = blue;

        // ties go to red, then green
        if (mx == red)
        begin
            side1_next.sector = SEC_RED;
            pos = green;
            sub = blue;
        end
        else if (mx == green)
        begin
            side1_next.sector = SEC_GREEN;
            pos = blue;
            sub = red;
        end
        else
        begin
            side1_next.sector = SEC_BLUE;
            pos = red;
            sub = green;
        end

        side1_next.neg   = (pos < sub);
        side1_next.grey  = (mx == mn);
        side1_next.value = mx;
        mag1_next        = (pos < sub) ? (sub - pos) : (pos - sub);
        delta1_next      = mx - mn;
    end

    // 60*x = 64x - 4x, 255*d = 256d - d
    always_comb
    begin
        num_hue2_next = NUM_W'({mag1_reg, 6'b0}) - NUM_W'({mag1_reg, 2'b0});
        num_sat2_next = {delta1_reg, 8'b0} - NUM_W'(delta1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg    <= side1_next;
            delta1_reg   <= delta1_next;
            mag1_reg     <= mag1_next;
            side2_reg    <= side1_reg;
            delta2_reg   <= delta1_reg;
            num_hue2_reg <= num_hue2_next;
            num_sat2_reg <= num_sat2_next;
        end
    end

    assign out_valid = valid2_reg;
    assign num_hue   = num_hue2_reg;
    assign num_sat   = num_sat2_reg;
    assign delta     = delta2_reg;
    assign side      = side2_reg;

endmodule

// ===== rtl/core/hsv_div.sv =====
// Pipelined restoring divider: one quotient bit per stage for hue and saturation.
`timescale 1ns / 1ps

module hsv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [hsv_pkg::NUM_W-1:0]     num_hue,
    input  logic [hsv_pkg::NUM_W-1:0]     num_sat,
    input  logic [hsv_pkg::CH_W-1:0]      delta,
    input  hsv_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [hsv_pkg::QUO_W-1:0]     quo_hue,
    output logic [hsv_pkg::QUO_W-1:0]     quo_sat,
    output hsv_pkg::side_t                side_out
);
    import hsv_pkg::*;

    // Both quotients stay below 256: 60*|diff| < 256*delta, 255*delta < 256*max.
    logic             valid_reg [1:QUO_W];
    logic [NUM_W-1:0] rh_reg    [1:QUO_W];
    logic [NUM_W-1:0] rs_reg    [1:QUO_W];
    logic [QUO_W-1:0] qh_reg    [1:QUO_W];
    logic [QUO_W-1:0] qs_reg    [1:QUO_W];
    logic [CH_W-1:0]  d_reg     [1:QUO_W];
    side_t            side_reg  [1:QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_stage
        localparam int SH = QUO_W - 1 - i;

        logic             valid_cur;
        logic [NUM_W-1:0] rh_cur, rs_cur;
        logic [QUO_W-1:0] qh_cur, qs_cur;
        logic [CH_W-1:0]  d_cur;
        side_t            side_cur;

        logic [NUM_W-1:0] dh, ds;
        logic             fit_h, fit_s;
        logic [NUM_W-1:0] rh_next, rs_next;
        logic [QUO_W-1:0] qh_next, qs_next;

        // first stage works straight off the inputs
        if (i == 0)
        begin : g_entry
            assign valid_cur = in_valid;
            assign rh_cur    = num_hue;
            assign rs_cur    = num_sat;
            assign qh_cur    = '0;
            assign qs_cur    = '0;
            assign d_cur     = delta;
            assign side_cur  = side_in;
        end
        else
        begin : g_link
            assign valid_cur = valid_reg[i];
            assign rh_cur    = rh_reg[i];
            assign rs_cur    = rs_reg[i];
            assign qh_cur    = qh_reg[i];
            assign qs_cur    = qs_reg[i];
            assign d_cur     = d_reg[i];
            assign side_cur  = side_reg[i];
        end

        always_comb
        begin
            dh      = NUM_W'(d_cur) << SH;
            ds      = NUM_W'(side_cur.value) << SH;
            fit_h   = (rh_cur >= dh);
            fit_s   = (rs_cur >= ds);
            rh_next = fit_h ? (rh_cur - dh) : rh_cur;
            rs_next = fit_s ? (rs_cur - ds) : rs_cur;
            qh_next = qh_cur;
            qs_next = qs_cur;
            qh_next[SH] = fit_h;
            qs_next[SH] = fit_s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rh_reg[i+1]   <= rh_next;
                rs_reg[i+1]   <= rs_next;
                qh_reg[i+1]   <= qh_next;
                qs_reg[i+1]   <= qs_next;
                d_reg[i+1]    <= d_cur;
                side_reg[i+1] <= side_cur;
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign quo_hue   = qh_reg[QUO_W];
    assign quo_sat   = qs_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

// ===== rtl/core/hsv_post.sv =====
// Output stage: sector offset, wrap of negative angles, grey override.
`timescale 1ns / 1ps

module hsv_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [hsv_pkg::QUO_W-1:0]     quo_hue,
    input  logic [hsv_pkg::QUO_W-1:0]     quo_sat,
    input  hsv_pkg::side_t                side,
    output logic                          out_valid,
    output logic [hsv_pkg::HUE_W-1:0]     hue,
    output logic [hsv_pkg::CH_W-1:0]      saturation,
    output logic [hsv_pkg::CH_W-1:0]      brightness
);
    import hsv_pkg::*;

    logic             valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [CH_W-1:0]  sat_reg, sat_next;
    logic [CH_W-1:0]  bright_reg;

    logic [HUE_W-1:0] ang;
    logic [HUE_W-1:0] base;

    always_comb
    begin
        ang = HUE_W'(quo_hue[ANG_W-1:0]);
        case (side.sector)
            SEC_GREEN: base = HUE_BASE_G;
            SEC_BLUE:  base = HUE_BASE_B;
            default:   base = '0;
        endcase

        if (side.grey)
            hue_next = '0;
        else if (side.neg && ang != '0)
            // red sector wraps to 300..359
            hue_next = ((side.sector == SEC_RED) ? HUE_FULL : base) - ang;
        else
            hue_next = base + ang;

        sat_next = side.grey ? '0 : quo_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= side.value;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;

endmodule

// ===== rtl/core/rgb_to_hsv_pixel_top.sv =====
// Top level of the 8-bit RGB to HSV pixel converter.
//
// Input stream s_axis: one pixel per item, tdata = {blue, green, red}.
// Output stream m_axis: one result per pixel, tdata = {pad, brightness,
// saturation, hue}; hue is whole degrees 0..359, grey pixels give hue 0
// and saturation 0.
// Throughput: one item per clock while m_axis is not stalled. The
// pipeline is 11 register stages deep: max/min, numerator scaling,
// eight divider stages (one quotient bit each for hue and saturation)
// and the output register.
// Reset clears every valid bit; the pipeline comes up empty and ready.
// When the receiver holds m_axis_tready low with a result waiting, the
// whole pipeline freezes, empty slots included, and s_axis_tready drops
// in the same cycle. Nothing is lost or repeated across a stall.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // hue[8:0], saturation[16:9], brightness[24:17], zero
);
    import hsv_pkg::*;

    logic             en;
    logic             prep_valid;
    logic [NUM_W-1:0] prep_num_hue, prep_num_sat;
    logic [CH_W-1:0]  prep_delta;
    side_t            prep_side;
    logic             div_valid;
    logic [QUO_W-1:0] div_quo_hue, div_quo_sat;
    side_t            div_side;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation, brightness;

    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    hsv_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (prep_valid),
        .num_hue   (prep_num_hue),
        .num_sat   (prep_num_sat),
        .delta     (prep_delta),
        .side      (prep_side)
    );

    hsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .num_hue   (prep_num_hue),
        .num_sat   (prep_num_sat),
        .delta     (prep_delta),
        .side_in   (prep_side),
        .out_valid (div_valid),
        .quo_hue   (div_quo_hue),
        .quo_sat   (div_quo_sat),
        .side_out  (div_side)
    );

    hsv_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (div_valid),
        .quo_hue    (div_quo_hue),
        .quo_sat    (div_quo_sat),
        .side       (div_side),
        .out_valid  (m_axis_tvalid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_axis_tdata = {7'b0, brightness, saturation, hue};

endmodule

// ===== rtl/core/hsv_chk.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps

module hsv_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[8:0] < 9'd360)
        else $error("hue out of range");

    // zero saturation only comes from a grey pixel
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:9] != 8'd0 || m_axis_tdata[8:0] == 9'd0))
        else $error("hue nonzero for grey pixel");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[24:17] != 8'd0 || m_axis_tdata[16:9] == 8'd0))
        else $error("saturation nonzero for black pixel");

    // input is taken whenever the output slot is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind rgb_to_hsv_pixel_top hsv_chk u_hsv_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/hsv_result_checker.sv =====
// Stream checker for the RGB to HSV converter: predicts each result and compares it.
`timescale 1ns / 1ps

module hsv_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    input  logic        pix_ready,
    input  logic [23:0] pix_data,     // red[7:0], green[15:8], blue[23:16]
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [31:0] res_data,     // hue[8:0], saturation[16:9], brightness[24:17], zero
    output int          fail_count,
    output int          pending
);
    import hsv_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } hsv_t;

    localparam int SECTOR_DEG = 60;
    localparam int SAT_SCALE  = 255;
    localparam int FULL_TURN  = int'(HUE_FULL);
    localparam int USED_BITS  = HUE_W + 2 * CH_W;

    hsv_t hsv_expect_q[$];
    int   fails;

    function automatic hsv_t convert_pixel(input logic [CH_W-1:0] r, g, b);
        int      red_i;
        int      grn_i;
        int      blu_i;
        int      peak;
        int      floor_v;
        int      delta;
        int      diff;
        int      base;
        int      angle;
        int      sat_i;
        sector_t sec;
        hsv_t    res;
        red_i = int'(r);
        grn_i = int'(g);
        blu_i = int'(b);
        peak = red_i;
        floor_v = red_i;
        if (grn_i > peak) peak = grn_i;
        if (blu_i > peak) peak = blu_i;
        if (grn_i < floor_v) floor_v = grn_i;
        if (blu_i < floor_v) floor_v = blu_i;
        delta = peak - floor_v;
        res = '0;
        res.brightness = peak[CH_W-1:0];
        // grey (black included) keeps hue and saturation at zero
        if (delta != 0)
        begin
            // ties favor red, then green
            if (peak == red_i)
                sec = SEC_RED;
            else if (peak == grn_i)
                sec = SEC_GREEN;
            else
                sec = SEC_BLUE;
            case (sec)
                SEC_RED:
                begin
                    diff = grn_i - blu_i;
                    base = 0;
                end
                SEC_GREEN:
                begin
                    diff = blu_i - red_i;
                    base = int'(HUE_BASE_G);
                end
                default:
                begin
                    diff = red_i - grn_i;
                    base = int'(HUE_BASE_B);
                end
            endcase
            // signed int division truncates toward zero
            angle = (SECTOR_DEG * diff) / delta;
            angle = angle + base;
            if (angle < 0) angle = angle + FULL_TURN;
            if (angle >= FULL_TURN) angle = angle - FULL_TURN;
            res.hue = angle[HUE_W-1:0];
            sat_i = (delta * SAT_SCALE) / peak;
            res.saturation = sat_i[CH_W-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        hsv_t want;
        hsv_t got;
        if (!rst_n)
        begin
            hsv_expect_q.delete();
            fails = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                got.hue        = res_data[HUE_W-1:0];
                got.saturation = res_data[HUE_W+CH_W-1:HUE_W];
                got.brightness = res_data[USED_BITS-1:HUE_W+CH_W];
                if (hsv_expect_q.size() == 0)
                begin
                    $error("result with no pixel waiting: hue %0d sat %0d val %0d",
                           got.hue, got.saturation, got.brightness);
                    fails = fails + 1;
                end
                else
                begin
                    want = hsv_expect_q.pop_front();
                    if (got.hue !== want.hue)
                    begin
                        $error("hue: expected %0d, got %0d", want.hue, got.hue);
                        fails = fails + 1;
                    end
                    if (got.saturation !== want.saturation)
                    begin
                        $error("saturation: expected %0d, got %0d",
                               want.saturation, got.saturation);
                        fails = fails + 1;
                    end
                    if (got.brightness !== want.brightness)
                    begin
                        $error("brightness: expected %0d, got %0d",
                               want.brightness, got.brightness);
                        fails = fails + 1;
                    end
                    if (res_data[31:USED_BITS] !== '0)
                    begin
                        $error("pad: expected 0, got %0h", res_data[31:USED_BITS]);
                        fails = fails + 1;
                    end
                end
            end
            // a result never leaves in the cycle its pixel enters, so pop before push
            if (pix_valid && pix_ready)
                hsv_expect_q.push_back(convert_pixel(pix_data[7:0], pix_data[15:8],
                                                     pix_data[23:16]));
            fail_count <= fails;
            pending <= hsv_expect_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the RGB to HSV converter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int PIXELS      = 1850;
    localparam int HOLD_AT     = 300;
    localparam int PAUSE_AT    = 900;
    localparam int QUIET_AT    = 1200;
    localparam int LONG_HOLD   = 200;
    localparam int DRAIN       = 20;
    localparam int STUCK_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // hue[8:0], saturation[16:9], brightness[24:17], zero

    int fail_count;
    int pending;
    int gap_pct = 0;
    int stall_pct = 0;
    int stuck_cycles = 0;
    bit hold_req = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rgb_to_hsv_pixel_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    hsv_result_checker u_hsv_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (s_axis_tvalid),
        .pix_ready  (s_axis_tready),
        .pix_data   (s_axis_tdata),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_data   (m_axis_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_pixel(input logic [7:0] r, g, b);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        case ($urandom_range(0, 9))
            6:
            begin
                g = r;
                b = r;
            end
            7:
            begin
                // two channels share the maximum
                case ($urandom_range(0, 2))
                    0:
                    begin
                        g = r;
                        b = 8'($urandom_range(0, r));
                    end
                    1:
                    begin
                        b = r;
                        g = 8'($urandom_range(0, r));
                    end
                    default:
                    begin
                        b = g;
                        r = 8'($urandom_range(0, g));
                    end
                endcase
            end
            8:
            begin
                r = 8'($urandom_range(0, 3));
                g = 8'($urandom_range(0, 3));
                b = 8'($urandom_range(0, 3));
            end
            9:
            begin
                case ($urandom_range(0, 2))
                    0:       r = 8'hFF;
                    1:       g = 8'hFF;
                    default: b = 8'hFF;
                endcase
            end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // receiver: random short stalls, plus one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners: grey, primaries, ties, sign of the sector angle, tiny values
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd5);
        send_pixel(8'd255, 8'd0,   8'd4);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd1,   8'd1,   8'd0);
        send_pixel(8'd170, 8'd85,  8'd255);
        send_pixel(8'd254, 8'd255, 8'd253);
        send_pixel(8'd0,   8'd255, 8'd128);
        send_pixel(8'd85,  8'd170, 8'd170);

        for (int n = 0; n < PIXELS; n++)
        begin
            if (n % 100 == 0)
            begin
                if (n >= QUIET_AT)
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       gap_pct = 0;
                        1:       gap_pct = 20;
                        default: gap_pct = 50;
                    endcase
                    case ($urandom_range(0, 2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        default: stall_pct = 50;
                    endcase
                end
            end
            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == PAUSE_AT)
            begin
                // let the pipe run dry before going on
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            send_random_pixel();
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/hsv_pkg.sv
rtl/core/hsv_prep.sv
rtl/core/hsv_div.sv
rtl/core/hsv_post.sv
rtl/core/rgb_to_hsv_pixel_top.sv
rtl/core/hsv_chk.sv
verif/hsv_result_checker.sv
verif/tb_top.sv
